FILE: rtl/mtd_pkg.sv
// Package for the Morse token decoder: widths, queue sizing, entry type and
// the code-to-character lookup. No dependencies.
package mtd_pkg;

   localparam int unsigned SYM_MAX     = 5;
   localparam int unsigned CNT_W       = 3;
   localparam int unsigned QDEPTH      = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_NONE    = 8'h00;

   // One queued job: optional leading space, then optional decoded character.
   typedef struct packed {
      logic       lead_space;
      logic       has_char;
      logic [7:0] ch;
   } entry_type;

   // Index is (1 << length) | symbols, dash = 1, newest symbol in bit 0.
   function automatic logic [7:0] code_char(input logic [5:0] idx);
      logic [7:0] c;
      unique case (idx)
         6'd2:    c = "E";
         6'd3:    c = "T";
         6'd4:    c = "I";
         6'd5:    c = "A";
         6'd6:    c = "N";
         6'd7:    c = "M";
         6'd8:    c = "S";
         6'd9:    c = "U";
         6'd10:   c = "R";
         6'd11:   c = "W";
         6'd12:   c = "D";
         6'd13:   c = "K";
         6'd14:   c = "G";
         6'd15:   c = "O";
         6'd16:   c = "H";
         6'd17:   c = "V";
         6'd18:   c = "F";
         6'd20:   c = "L";
         6'd22:   c = "P";
         6'd23:   c = "J";
         6'd24:   c = "B";
         6'd25:   c = "X";
         6'd26:   c = "C";
         6'd27:   c = "Y";
         6'd28:   c = "Z";
         6'd29:   c = "Q";
         6'd32:   c = "5";
         6'd33:   c = "4";
         6'd35:   c = "3";
         6'd39:   c = "2";
         6'd47:   c = "1";
         6'd48:   c = "6";
         6'd56:   c = "7";
         6'd60:   c = "8";
         6'd62:   c = "9";
         6'd63:   c = "0";
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/mtd_ifs.sv
// Valid/ready channel interfaces for the Morse token decoder.
// Request carries input bytes, response carries decoded characters.
interface mtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_text;

   modport source (output valid, output in_char, output end_of_text, input ready);
   modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface mtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

FILE: rtl/morse_token_decoder_top.sv
// Top level of the Morse token decoder: front end, job queue, back end.
// Uses mtd_pkg, mtd_req_if, mtd_rsp_if, mtd_front, mtd_queue, mtd_back.
//
//   channel   dir  payload                   handshake
//   req_chan  in   in_char[8], end_of_text   valid/ready
//   rsp_chan  out  out_char[8], last_of_run  valid/ready
//
// One request per cycle while the queue is not full; each job is registered
// in the job queue, then the output register. A two-response request holds
// the back end for both; the two-entry queue lets the front keep accepting.
// Synchronous active-high reset; ready drops only when the job queue is full.
module morse_token_decoder_top (
   input  logic      clock,
   input  logic      reset,
   mtd_req_if.sink   req_chan,
   mtd_rsp_if.source rsp_chan
);
   import mtd_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   mtd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mtd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: rtl/mtd_front.sv
// Front end: accepts request bytes, tracks the pending token and text start,
// and pushes output jobs to the queue. Uses mtd_pkg.
module mtd_front (
   input  logic               clock,
   input  logic               reset,
   mtd_req_if.sink            req_chan,
   input  logic               q_full,
   output logic               push,
   output mtd_pkg::entry_type push_entry
);
   import mtd_pkg::*;

   logic [4:0]       symbol_bits_ff, symbol_bits_in;
   logic [CNT_W-1:0] symbol_count_ff, symbol_count_in;
   logic             token_invalid_ff, token_invalid_in;
   logic             at_text_start_ff, at_text_start_in;

   logic             accept;
   logic             is_ws;
   logic             is_sym;
   logic             finish;
   logic [4:0]       upd_bits;
   logic [CNT_W-1:0] upd_count;
   logic             upd_invalid;
   logic [5:0]       idx;
   logic [7:0]       dec_char;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;

   assign is_ws  = (req_chan.in_char == CHAR_SPACE) ||
                   ((req_chan.in_char >= CHAR_TAB) && (req_chan.in_char <= CHAR_CR));
   assign is_sym = (req_chan.in_char == CHAR_DOT) || (req_chan.in_char == CHAR_DASH);
   assign finish = is_ws || req_chan.end_of_text;

   always_comb begin
      upd_bits    = symbol_bits_ff;
      upd_count   = symbol_count_ff;
      upd_invalid = token_invalid_ff;
      if (is_sym) begin
         if (symbol_count_ff >= CNT_W'(SYM_MAX)) begin
            upd_invalid = 1'b1;
         end else begin
            upd_bits  = {symbol_bits_ff[3:0], (req_chan.in_char == CHAR_DASH)};
            upd_count = symbol_count_ff + CNT_W'(1);
         end
      end else if (!is_ws) begin
         upd_invalid = 1'b1;
      end
   end

   assign idx = (6'd1 << upd_count) | {1'b0, upd_bits};

   always_comb begin
      dec_char = CHAR_NONE;
      if (finish && !upd_invalid && (upd_count != '0)) begin
         dec_char = code_char(idx);
      end
   end

   always_comb begin
      push_entry.lead_space = at_text_start_ff;
      push_entry.has_char   = (dec_char != CHAR_NONE);
      push_entry.ch         = dec_char;
      push = accept && (at_text_start_ff || (dec_char != CHAR_NONE));
   end

   always_comb begin
      symbol_bits_in   = symbol_bits_ff;
      symbol_count_in  = symbol_count_ff;
      token_invalid_in = token_invalid_ff;
      at_text_start_in = at_text_start_ff;
      if (accept) begin
         at_text_start_in = req_chan.end_of_text;
         if (finish) begin
            symbol_bits_in   = '0;
            symbol_count_in  = '0;
            token_invalid_in = 1'b0;
         end else begin
            symbol_bits_in   = upd_bits;
            symbol_count_in  = upd_count;
            token_invalid_in = upd_invalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_bits_ff   <= '0;
         symbol_count_ff  <= '0;
         token_invalid_ff <= 1'b0;
         at_text_start_ff <= 1'b1;
      end else begin
         symbol_bits_ff   <= symbol_bits_in;
         symbol_count_ff  <= symbol_count_in;
         token_invalid_ff <= token_invalid_in;
         at_text_start_ff <= at_text_start_in;
      end
   end

endmodule

FILE: rtl/mtd_queue.sv
// Small FIFO of output jobs between the front and back ends.
// Uses mtd_pkg for depth and entry type.
module mtd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mtd_pkg::entry_type head_entry
);
   import mtd_pkg::*;

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/mtd_back.sv
// Back end: expands queued jobs into one or two responses through an
// output register. Uses mtd_pkg and mtd_rsp_if.
module mtd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  mtd_pkg::entry_type head_entry,
   output logic               pop,
   mtd_rsp_if.source          rsp_chan
);
   import mtd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       space_sent_ff, space_sent_in;
   logic       load;

   assign load = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      space_sent_in = space_sent_ff;
      pop           = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (head_entry.lead_space && !space_sent_ff) begin
            rsp_char_in = CHAR_SPACE;
            rsp_last_in = !head_entry.has_char;
            if (head_entry.has_char) begin
               space_sent_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            rsp_char_in   = head_entry.ch;
            rsp_last_in   = 1'b1;
            space_sent_in = 1'b0;
            pop           = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         space_sent_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         space_sent_ff <= space_sent_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_char    = rsp_char_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule
